@@ design/obdpid_pkg.sv @@
// ----------------------------------------------------------------------------
// obdpid_pkg
// Shared types and constants of the OBD-II reply decoder and boost estimator.
// ----------------------------------------------------------------------------
package obdpid_pkg;

  // Parameter identifiers of the mode 01 replies that are decoded.
  localparam logic [7:0] PID_COOLANT = 8'h05;
  localparam logic [7:0] PID_RPM     = 8'h0C;
  localparam logic [7:0] PID_SPEED   = 8'h0D;
  localparam logic [7:0] PID_INTAKE  = 8'h0F;
  localparam logic [7:0] PID_FLOW    = 8'h10;

  // Reset value of the reply identifier.
  localparam logic [10:0] REPLY_ID_RST = 11'h7E8;

  // Gauge codes on the update channel.
  localparam logic [1:0] GAUGE_SPEED   = 2'd0;
  localparam logic [1:0] GAUGE_COOLANT = 2'd1;
  localparam logic [1:0] GAUGE_BOOST   = 2'd2;

  // Sentinels of the shown values after reset.
  localparam logic [7:0]         SHOWN_SPEED_RST = 8'd255;
  localparam logic signed [15:0] SHOWN_VALUE_RST = 16'sd32767;

  // Boost arithmetic: gain in Q20, temperature offsets and saturation.
  localparam logic [24:0]        GAIN_Q20    = 25'd18077138;
  localparam logic [8:0]         TEMP_OFFSET = 9'd40;
  localparam logic signed [9:0]  KELVIN_OFS  = 10'sd273;
  localparam logic [15:0]        CENTI_SCALE = 16'd100;
  localparam logic [15:0]        CENTI_FRAC  = 16'd15;
  localparam logic [27:0]        RPM_SCALE   = 28'd2500;
  localparam logic [14:0]        BOOST_SAT   = 15'd32767;
  localparam logic signed [15:0] BOOST_OFS   = 16'sd100;

  // Divider geometry: dividend is the product over 2^20, divisor rpm*2500.
  localparam int unsigned PROD_W    = 57;
  localparam int unsigned DVD_W     = 37;
  localparam int unsigned DEN_W     = 28;
  localparam int unsigned CNT_W     = 6;
  localparam logic [5:0]  DIV_LAST  = 6'd36;

  // Operation decoded by the front end for the back end.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_COOLANT,
    OP_RPM,
    OP_SPEED,
    OP_INTAKE,
    OP_FLOW
  } op_e;

  // One queued command word.
  typedef struct packed {
    op_e         op;
    logic [15:0] data;
  } cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ design/obdpid_fifo.sv @@
// ----------------------------------------------------------------------------
// obdpid_fifo
// Short first-in first-out queue of command words between front and back.
// ----------------------------------------------------------------------------
module obdpid_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  obdpid_pkg::cmd_t  push_data_i,
  input  logic              pop_i,
  output obdpid_pkg::cmd_t  pop_data_o,
  output obdpid_pkg::q_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  obdpid_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  // Pointer advance with wrap at the queue depth.
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
    next_ptr = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Storage is written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

@@ design/obdpid_front.sv @@
// ----------------------------------------------------------------------------
// obdpid_front
// Accepts received frames, matches the reply identifier and classifies the
// PID into a command word for the back end. Holds the reply_id register.
// ----------------------------------------------------------------------------
module obdpid_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [10:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [10:0]      frame_id_i,
  input  logic [7:0]       pid_code_i,
  input  logic [7:0]       byte_a_i,
  input  logic [7:0]       byte_b_i,
  input  obdpid_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output obdpid_pkg::cmd_t push_data_o
);

  logic [10:0]     reply_id_q;
  obdpid_pkg::op_e op;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_id_q <= obdpid_pkg::REPLY_ID_RST;
    end else if (cfg_valid) begin
      reply_id_q <= cfg_data;
    end
  end

  // Classify the frame: foreign frames and unknown PIDs still go through,
  // as every frame triggers a boost estimate and change check.
  always_comb begin
    op = obdpid_pkg::OP_NONE;
    if (frame_id_i == reply_id_q) begin
      case (pid_code_i)
        obdpid_pkg::PID_COOLANT: op = obdpid_pkg::OP_COOLANT;
        obdpid_pkg::PID_RPM:     op = obdpid_pkg::OP_RPM;
        obdpid_pkg::PID_SPEED:   op = obdpid_pkg::OP_SPEED;
        obdpid_pkg::PID_INTAKE:  op = obdpid_pkg::OP_INTAKE;
        obdpid_pkg::PID_FLOW:    op = obdpid_pkg::OP_FLOW;
        default:                 op = obdpid_pkg::OP_NONE;
      endcase
    end
  end

  // Hand the word to the queue while it has room.
  assign in_stall         = q_stat_i.full;
  assign push_o           = in_valid && !q_stat_i.full;
  assign push_data_o.op   = op;
  assign push_data_o.data = {byte_a_i, byte_b_i};

endmodule

@@ design/obdpid_back.sv @@
// ----------------------------------------------------------------------------
// obdpid_back
// Applies queued commands to the engine values, estimates boost with a
// multiply chain and a restoring divider, and emits change-only updates.
// ----------------------------------------------------------------------------
module obdpid_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_avail_i,
  input  obdpid_pkg::cmd_t   cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         gauge_o,
  output logic signed [15:0] value_o,
  output logic               last_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_PROD = 3'd2;
  localparam logic [2:0] S_NUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_q, state_d;

  // Engine values and shown values.
  logic signed [8:0]  coolant_q, intake_q;
  logic [15:0]        rpm_q, flow_q;
  logic [7:0]         speed_q;
  logic [7:0]         shown_speed_q;
  logic signed [15:0] shown_coolant_q, shown_boost_q;

  // Arithmetic datapath.
  logic [15:0]                        tk_q;
  logic [obdpid_pkg::DEN_W-1:0]       den_q;
  logic                               rpm_zero_q;
  logic [31:0]                        p1_q;
  logic [obdpid_pkg::DVD_W-1:0]       dvd_q;
  logic [obdpid_pkg::DEN_W-1:0]       rem_q;
  logic [obdpid_pkg::CNT_W-1:0]       cnt_q;
  logic [2:0]                         pend_q;
  logic signed [15:0]                 boost_q;

  logic signed [9:0]                  kelvin;
  logic [obdpid_pkg::PROD_W-1:0]      num_full;
  logic [obdpid_pkg::DEN_W:0]         rem_sh;
  logic                               rem_ge;
  logic [14:0]                        q_sat;
  logic signed [15:0]                 boost;
  logic signed [15:0]                 coolant_ext;

  // Output register.
  logic               out_valid_q;
  logic [1:0]         gauge_q;
  logic signed [15:0] value_q;
  logic               last_q;

  // Emit selection.
  logic               out_free, load;
  logic [1:0]         sel_gauge;
  logic signed [15:0] sel_value;
  logic [2:0]         pend_rest;

  // Arithmetic helpers.
  assign kelvin      = {intake_q[8], intake_q} + obdpid_pkg::KELVIN_OFS;
  assign num_full    = obdpid_pkg::PROD_W'(p1_q) * obdpid_pkg::PROD_W'(obdpid_pkg::GAIN_Q20);
  assign rem_sh      = {rem_q, dvd_q[obdpid_pkg::DVD_W-1]};
  assign rem_ge      = (rem_sh >= {1'b0, den_q});
  assign q_sat       = (|dvd_q[obdpid_pkg::DVD_W-1:15]) ? obdpid_pkg::BOOST_SAT
                                                       : dvd_q[14:0];
  assign boost       = rpm_zero_q ? 16'sd0
                                  : $signed({1'b0, q_sat}) - obdpid_pkg::BOOST_OFS;
  assign coolant_ext = 16'(coolant_q);

  // Pick the first pending gauge in speed, coolant, boost order.
  always_comb begin
    if (pend_q[0]) begin
      sel_gauge = obdpid_pkg::GAUGE_SPEED;
      sel_value = $signed({8'd0, speed_q});
    end else if (pend_q[1]) begin
      sel_gauge = obdpid_pkg::GAUGE_COOLANT;
      sel_value = coolant_ext;
    end else begin
      sel_gauge = obdpid_pkg::GAUGE_BOOST;
      sel_value = boost_q;
    end
  end

  assign pend_rest = pend_q & (pend_q - 3'd1);
  assign out_free  = !out_valid_q || !out_stall;
  assign load      = (state_q == S_EMIT) && (pend_q != 3'd0) && out_free;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_avail_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (cmd_avail_i) state_d = S_PREP;
      S_PREP: state_d = S_PROD;
      S_PROD: state_d = S_NUM;
      S_NUM:  state_d = rpm_zero_q ? S_EVAL : S_DIV;
      S_DIV:  if (cnt_q == obdpid_pkg::DIV_LAST) state_d = S_EVAL;
      S_EVAL: state_d = S_EMIT;
      S_EMIT: begin
        if (pend_q == 3'd0 || (load && pend_rest == 3'd0)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control, engine values, shown values and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      coolant_q       <= '0;
      intake_q        <= '0;
      rpm_q           <= '0;
      flow_q          <= '0;
      speed_q         <= '0;
      shown_speed_q   <= obdpid_pkg::SHOWN_SPEED_RST;
      shown_coolant_q <= obdpid_pkg::SHOWN_VALUE_RST;
      shown_boost_q   <= obdpid_pkg::SHOWN_VALUE_RST;
      pend_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      // Capture the decoded engine value.
      if (cmd_pop_o) begin
        case (cmd_i.op)
          obdpid_pkg::OP_COOLANT:
            coolant_q <= $signed({1'b0, cmd_i.data[15:8]} - obdpid_pkg::TEMP_OFFSET);
          obdpid_pkg::OP_RPM:    rpm_q   <= cmd_i.data;
          obdpid_pkg::OP_SPEED:  speed_q <= cmd_i.data[15:8];
          obdpid_pkg::OP_INTAKE:
            intake_q <= $signed({1'b0, cmd_i.data[15:8]} - obdpid_pkg::TEMP_OFFSET);
          obdpid_pkg::OP_FLOW:   flow_q  <= cmd_i.data;
          default: ;
        endcase
      end
      // Work out which gauges changed.
      if (state_q == S_EVAL) begin
        pend_q <= {boost != shown_boost_q,
                   coolant_ext != shown_coolant_q,
                   speed_q != shown_speed_q};
      end else if (load) begin
        pend_q <= pend_rest;
      end
      // Load one update and note it as shown.
      if (load) begin
        out_valid_q <= 1'b1;
        case (sel_gauge)
          obdpid_pkg::GAUGE_SPEED:   shown_speed_q   <= speed_q;
          obdpid_pkg::GAUGE_COOLANT: shown_coolant_q <= coolant_ext;
          default:                   shown_boost_q   <= boost_q;
        endcase
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: multiply chain, divider and output payload.
  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP) begin
      tk_q       <= 16'(kelvin[8:0]) * obdpid_pkg::CENTI_SCALE + obdpid_pkg::CENTI_FRAC;
      den_q      <= obdpid_pkg::DEN_W'(rpm_q) * obdpid_pkg::RPM_SCALE;
      rpm_zero_q <= (rpm_q == 16'd0);
    end
    if (state_q == S_PROD) begin
      p1_q <= 32'(flow_q) * 32'(tk_q);
    end
    if (state_q == S_NUM) begin
      dvd_q <= num_full[obdpid_pkg::PROD_W-1:20];
      rem_q <= '0;
      cnt_q <= '0;
    end
    // One quotient bit per cycle, restoring.
    if (state_q == S_DIV) begin
      rem_q <= rem_ge ? obdpid_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                      : rem_sh[obdpid_pkg::DEN_W-1:0];
      dvd_q <= {dvd_q[obdpid_pkg::DVD_W-2:0], rem_ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (state_q == S_EVAL) begin
      boost_q <= boost;
    end
    if (load) begin
      gauge_q <= sel_gauge;
      value_q <= sel_value;
      last_q  <= (pend_rest == 3'd0);
    end
  end

  assign out_valid = out_valid_q;
  assign gauge_o   = gauge_q;
  assign value_o   = value_q;
  assign last_o    = last_q;

endmodule

@@ design/obd_pid_decode_boost_estimate.sv @@
// ----------------------------------------------------------------------------
// obd_pid_decode_boost_estimate
// Decodes OBD-II mode 01 replies from received CAN frames, estimates boost
// and sends change-only gauge updates for speed, coolant and boost.
// ----------------------------------------------------------------------------
// Sequence: a taken frame passes the queue, then the prepare, product,
// numerator, 37-step restoring divider, evaluate and emit states; the
// divider is skipped when the rpm count is zero. Further updates of the same
// frame follow one per cycle unless stalled; one frame is worked at a time.
// Reset: asynchronous, active low; engine values clear to zero, shown values
// go to their sentinels and reply_id to 0x7E8. A two-word queue absorbs frames.
module obd_pid_decode_boost_estimate #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [10:0]        frame_id_i,
  input  logic [7:0]         pid_code_i,
  input  logic [7:0]         byte_a_i,
  input  logic [7:0]         byte_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         gauge_o,
  output logic signed [15:0] value_o,
  output logic               last_o
);

  obdpid_pkg::q_stat_t q_stat;
  obdpid_pkg::cmd_t    push_data, pop_data;
  logic                push, pop;

  // Front end: identifier match and PID classification.
  obdpid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid   (cfg_valid_i),
    .cfg_ready   (cfg_ready_o),
    .cfg_data    (cfg_data_i),
    .in_valid    (in_valid_i),
    .in_stall    (in_stall_o),
    .frame_id_i  (frame_id_i),
    .pid_code_i  (pid_code_i),
    .byte_a_i    (byte_a_i),
    .byte_b_i    (byte_b_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Command queue between the two ends.
  obdpid_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // Back end: value capture, boost estimate and updates.
  obdpid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_avail_i (!q_stat.empty),
    .cmd_i       (pop_data),
    .cmd_pop_o   (pop),
    .out_valid   (out_valid_o),
    .out_stall   (out_stall_i),
    .gauge_o     (gauge_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  // The queue is never reported full and empty at once.
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reported full and empty together");

  // A word pushed into an empty queue is still there in the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && q_stat.empty |=> !q_stat.empty)
    else $error("pushed word lost from the queue");

  // A boost update never lies below the offset.
  a_boost_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gauge_o == obdpid_pkg::GAUGE_BOOST |-> value_o >= -16'sd100)
    else $error("boost update below offset");

  // A speed update carries an unsigned byte.
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gauge_o == obdpid_pkg::GAUGE_SPEED |-> value_o[15:8] == 8'd0)
    else $error("speed update out of range");

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the OBD-II reply decoder and boost estimator.
// Frames are fed from a queue with random gaps while the update side is
// stalled in random bursts. Each accepted frame is run through a local
// model of the decoder, which queues the gauge updates the block should
// send; every accepted update is checked against the oldest queued one.
// The reply identifier is changed between phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_top;

  // One received frame as seen on the input channel.
  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  pid_code;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
  } frame_t;

  // One gauge update as seen on the output channel.
  typedef struct packed {
    logic [1:0]         gauge;
    logic signed [15:0] value;
    logic               last;
  } gauge_update_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [10:0]        cfg_data_i  = obdpid_pkg::REPLY_ID_RST;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [10:0]        frame_id_i  = '0;
  logic [7:0]         pid_code_i  = '0;
  logic [7:0]         byte_a_i    = '0;
  logic [7:0]         byte_b_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         gauge_o;
  logic signed [15:0] value_o;
  logic               last_o;

  // Frames waiting to be offered and updates the block still owes.
  frame_t        frames_pending[$];
  gauge_update_t updates_due[$];

  int unsigned frames_offered = 0;
  int unsigned frames_taken   = 0;
  int unsigned frame_gap      = 0;
  int unsigned stall_left     = 0;
  int unsigned mismatches     = 0;
  bit          idle_en        = 1'b1;

  // Local copy of the decoder state.
  logic [10:0] reply_id_m    = obdpid_pkg::REPLY_ID_RST;
  int          coolant_m     = 0;
  int          intake_m      = 0;
  logic [15:0] rpm_m         = '0;
  logic [7:0]  speed_m       = '0;
  logic [15:0] flow_m        = '0;
  logic [7:0]  shown_speed_m = obdpid_pkg::SHOWN_SPEED_RST;
  int          shown_cool_m  = 32767;
  int          shown_boost_m = 32767;

  obd_pid_decode_boost_estimate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .frame_id_i  (frame_id_i),
    .pid_code_i  (pid_code_i),
    .byte_a_i    (byte_a_i),
    .byte_b_i    (byte_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gauge_o     (gauge_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  // Clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Boost in centibar relative from the current engine values.
  function automatic int boost_estimate();
    longint unsigned tk100;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    if (rpm_m == 16'd0) return 0;
    tk100 = longint'(100 * (intake_m + 273) + 15);
    num   = longint'(flow_m) * tk100 * longint'(obdpid_pkg::GAIN_Q20);
    den   = longint'(rpm_m) * 64'd2500 * (64'd1 << 20);
    q     = num / den;
    if (q > 64'd32767) q = 64'd32767;
    return int'(q) - 100;
  endfunction

  // Captures the frame's value and queues the updates that follow from it.
  function automatic void decode_frame(input frame_t f);
    gauge_update_t batch[$];
    gauge_update_t u;
    int boost;
    if (f.frame_id == reply_id_m) begin
      case (f.pid_code)
        obdpid_pkg::PID_COOLANT: coolant_m = int'(f.byte_a) - 40;
        obdpid_pkg::PID_RPM:     rpm_m     = {f.byte_a, f.byte_b};
        obdpid_pkg::PID_SPEED:   speed_m   = f.byte_a;
        obdpid_pkg::PID_INTAKE:  intake_m  = int'(f.byte_a) - 40;
        obdpid_pkg::PID_FLOW:    flow_m    = {f.byte_a, f.byte_b};
        default: ;
      endcase
    end
    boost = boost_estimate();
    u.last = 1'b0;
    if (speed_m != shown_speed_m) begin
      u.gauge = obdpid_pkg::GAUGE_SPEED;
      u.value = {8'd0, speed_m};
      batch.push_back(u);
      shown_speed_m = speed_m;
    end
    if (coolant_m != shown_cool_m) begin
      u.gauge = obdpid_pkg::GAUGE_COOLANT;
      u.value = 16'(coolant_m);
      batch.push_back(u);
      shown_cool_m = coolant_m;
    end
    if (boost != shown_boost_m) begin
      u.gauge = obdpid_pkg::GAUGE_BOOST;
      u.value = 16'(boost);
      batch.push_back(u);
      shown_boost_m = boost;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) updates_due.push_back(batch[i]);
  endfunction

  // Input driver: holds a stalled word, otherwise offers the next frame or a gap.
  always @(negedge clk_i) begin : frame_driver
    frame_t nf;
    if (!(in_valid_i && frames_taken != frames_offered)) begin
      if (frame_gap > 0) begin
        frame_gap--;
        in_valid_i <= 1'b0;
      end else if (frames_pending.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        frame_gap = $urandom_range(0, 18);
        in_valid_i <= 1'b0;
      end else begin
        nf = frames_pending.pop_front();
        frame_id_i <= nf.frame_id;
        pid_code_i <= nf.pid_code;
        byte_a_i   <= nf.byte_a;
        byte_b_i   <= nf.byte_b;
        in_valid_i <= 1'b1;
        frames_offered++;
      end
    end
  end

  // Update side back-pressure in random bursts.
  always @(negedge clk_i) begin : update_stall
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: checks each accepted update and models each accepted frame.
  always @(posedge clk_i) begin : monitor
    gauge_update_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (updates_due.size() == 0) begin
          $error("unexpected update: gauge %0d value %0d last %0d",
                 gauge_o, value_o, last_o);
          mismatches++;
        end else begin
          want = updates_due.pop_front();
          if (gauge_o !== want.gauge) begin
            $error("gauge: expected %0d, got %0d", want.gauge, gauge_o);
            mismatches++;
          end
          if (value_o !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        decode_frame('{frame_id_i, pid_code_i, byte_a_i, byte_b_i});
        frames_taken++;
      end
    end
  end

  // Writes the reply identifier; only called with the block idle.
  task automatic write_reply_id(input logic [10:0] id);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    reply_id_m = id;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every frame is taken and every update has arrived, then lets
  // any frames that cause no update finish inside the block.
  task automatic drain_block();
    while (frames_pending.size() != 0 || in_valid_i || updates_due.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic add_frame(input logic [10:0] id, input logic [7:0] pid,
                           input logic [7:0] a, input logic [7:0] b);
    frames_pending.push_back('{id, pid, a, b});
  endtask

  // Random frames, mostly well-formed replies of the known PIDs.
  task automatic queue_random_frames(input int n);
    logic [7:0]  known[5];
    logic [10:0] id;
    logic [7:0]  pid;
    logic [7:0]  a;
    known = '{obdpid_pkg::PID_COOLANT, obdpid_pkg::PID_RPM, obdpid_pkg::PID_SPEED,
              obdpid_pkg::PID_INTAKE, obdpid_pkg::PID_FLOW};
    repeat (n) begin
      id  = ($urandom_range(0, 3) != 0) ? reply_id_m : 11'($urandom_range(0, 2047));
      pid = ($urandom_range(0, 4) != 0) ? known[$urandom_range(0, 4)]
                                        : 8'($urandom_range(0, 255));
      a   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                        : 8'($urandom_range(0, 255));
      add_frame(id, pid, a, 8'($urandom_range(0, 255)));
    end
  endtask

  // Main sequence: reset, directed frames, then random phases.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames with the reset reply identifier.
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_SPEED,   8'd0,   8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_SPEED,   8'd255, 8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_SPEED,   8'd255, 8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_COOLANT, 8'd0,   8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_COOLANT, 8'd255, 8'd255);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_INTAKE,  8'd0,   8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_FLOW,    8'd255, 8'd255);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_RPM,     8'd0,   8'd1);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_INTAKE,  8'd255, 8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_RPM,     8'd255, 8'd255);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_FLOW,    8'd0,   8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_FLOW,    8'h12,  8'h34);
    add_frame(obdpid_pkg::REPLY_ID_RST, 8'h00,                   8'd255, 8'd255);
    add_frame(obdpid_pkg::REPLY_ID_RST, 8'hFF,                   8'd0,   8'd0);
    add_frame(11'd0,                    obdpid_pkg::PID_SPEED,   8'd7,   8'd0);
    add_frame(11'd2047,                 obdpid_pkg::PID_COOLANT, 8'd9,   8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST ^ 11'd1, obdpid_pkg::PID_RPM, 8'd0, 8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_RPM,     8'd0,   8'd0);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_SPEED,   8'h55,  8'hAA);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_RPM,     8'hAA,  8'h55);
    add_frame(obdpid_pkg::REPLY_ID_RST, obdpid_pkg::PID_FLOW,    8'h55,  8'hAA);
    drain_block();

    // Random phases over several reply identifiers, the extremes among them.
    write_reply_id(11'd0);
    queue_random_frames(120);
    drain_block();

    idle_en = 1'b0;
    write_reply_id(11'd2047);
    queue_random_frames(120);
    drain_block();

    idle_en = 1'b1;
    write_reply_id(11'($urandom_range(1, 2046)));
    queue_random_frames(120);
    drain_block();

    // Last part without any idling.
    idle_en = 1'b0;
    write_reply_id(obdpid_pkg::REPLY_ID_RST);
    queue_random_frames(120);
    drain_block();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung block.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
